@@ rtl/xs64r_pkg.sv @@
package xs64r_pkg;

    localparam int unsigned STATE_W   = 64;
    localparam int unsigned HALF_W    = 32;
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 168;

    localparam logic [63:0] MULT_CONST = 64'd2685821657736338717;
    localparam logic [63:0] SEED_RESET = 64'd1;
    localparam logic [63:0] PCT_DIV    = 64'd100;

    localparam int unsigned SHIFT_A = 12;
    localparam int unsigned SHIFT_B = 25;
    localparam int unsigned SHIFT_C = 27;

    // radix-4 remainder unit
    localparam int unsigned DIV_STEPS = STATE_W / 2;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        FUNC_RAW   = 2'd0,
        FUNC_RANGE = 2'd1,
        FUNC_PCT   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_LL   = 2'd1,
        MUL_HL   = 2'd2,
        MUL_LH   = 2'd3
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADV,
        ST_MUL_LL,
        ST_MUL_HL,
        ST_MUL_LH,
        ST_SUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic    seed_load;
        logic    in_load;
        logic    adv;
        mul_op_t mul_op;
        logic    raw_load;
        logic    div_start;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } ctrl_stat_t;

endpackage

@@ rtl/xorshift64star_range_rng_top.sv @@
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   s_tdata, s_tuser (request kind)
// m_       out  m_tvalid/m_tready   m_tdata
// cfg_     in   cfg_valid/cfg_ready cfg_data (seed)
//
// one request at a time; range and percent requests that divide take
// 32 radix-4 remainder steps in the divider
// the state updates in ST_ADV, the 64-bit multiply takes three passes of one 32x32 unit
// aresetn is synchronous; after reset the state holds 1
// a result waiting on m_tready holds its word; the next request is still accepted
// seed writes are taken only while no request is in progress
module xorshift64star_range_rng_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // range_min[31:0], range_max[63:32], chance[70:64]
    input  logic [xs64r_pkg::S_TDATA_W-1:0]   s_tdata,
    // func[1:0]
    input  logic [xs64r_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // raw_value[63:0], range_value[95:64], chance_hit[96], range_error[97],
    // state_now[161:98]
    output logic [xs64r_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [63:0]                       cfg_data
);

    xs64r_pkg::ctrl_cmd_t  cmd;
    xs64r_pkg::ctrl_stat_t stat;

    xs64r_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    xs64r_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_data (cfg_data),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

@@ rtl/xs64r_div.sv @@
module xs64r_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] rem
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [xs64r_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [63:0]                         rem_reg;
    logic [63:0]                         quo_reg;
    logic [63:0]                         d1_reg;
    logic [65:0]                         d3_reg;

    logic [65:0] part;
    logic [66:0] diff1;
    logic [66:0] diff2;
    logic [66:0] diff3;
    logic [63:0] rem_next;
    logic        last;

    assign part  = {rem_reg, quo_reg[63:62]};
    assign diff3 = {1'b0, part} - {1'b0, d3_reg};
    assign diff2 = {1'b0, part} - {2'b00, d1_reg, 1'b0};
    assign diff1 = {1'b0, part} - {3'b000, d1_reg};
    assign last  = (cnt_reg == xs64r_pkg::DIV_CNT_W'(xs64r_pkg::DIV_STEPS - 1));

    // pick the largest multiple of the divisor that fits
    always_comb begin
        if (!diff3[66]) begin
            rem_next = diff3[63:0];
        end else if (!diff2[66]) begin
            rem_next = diff2[63:0];
        end else if (!diff1[66]) begin
            rem_next = diff1[63:0];
        end else begin
            rem_next = part[63:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            d1_reg  <= divisor;
            d3_reg  <= {2'b00, divisor} + {1'b0, divisor, 1'b0};
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[61:0], 2'b00};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/xs64r_ctrl.sv @@
module xs64r_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  xs64r_pkg::ctrl_stat_t stat,
    output xs64r_pkg::ctrl_cmd_t  cmd
);

    xs64r_pkg::ctrl_state_t state_reg;
    xs64r_pkg::ctrl_state_t state_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= xs64r_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.mul_op    = xs64r_pkg::MUL_NONE;
        s_tready      = 1'b0;
        cfg_ready     = 1'b0;
        unique case (state_reg)
            xs64r_pkg::ST_IDLE: begin
                s_tready      = 1'b1;
                cfg_ready     = 1'b1;
                cmd.seed_load = cfg_valid;
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = xs64r_pkg::ST_ADV;
                end
            end
            xs64r_pkg::ST_ADV: begin
                cmd.adv    = 1'b1;
                state_next = xs64r_pkg::ST_MUL_LL;
            end
            xs64r_pkg::ST_MUL_LL: begin
                cmd.mul_op = xs64r_pkg::MUL_LL;
                state_next = xs64r_pkg::ST_MUL_HL;
            end
            xs64r_pkg::ST_MUL_HL: begin
                cmd.mul_op = xs64r_pkg::MUL_HL;
                state_next = xs64r_pkg::ST_MUL_LH;
            end
            xs64r_pkg::ST_MUL_LH: begin
                cmd.mul_op = xs64r_pkg::MUL_LH;
                state_next = xs64r_pkg::ST_SUM;
            end
            xs64r_pkg::ST_SUM: begin
                cmd.raw_load = 1'b1;
                state_next   = stat.need_div ? xs64r_pkg::ST_DIV_START : xs64r_pkg::ST_DONE;
            end
            xs64r_pkg::ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = xs64r_pkg::ST_DIV_WAIT;
            end
            xs64r_pkg::ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    state_next = xs64r_pkg::ST_DONE;
                end
            end
            xs64r_pkg::ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = xs64r_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = xs64r_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ rtl/xs64r_dp.sv @@
module xs64r_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [xs64r_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [xs64r_pkg::S_TUSER_W-1:0]     s_tuser,
    input  logic [63:0]                         cfg_data,
    output logic [xs64r_pkg::M_TDATA_W-1:0]     m_tdata,
    input  xs64r_pkg::ctrl_cmd_t                cmd,
    output xs64r_pkg::ctrl_stat_t               stat
);

    logic [63:0] rng_state_reg;
    logic [63:0] rng_state_next;
    logic [63:0] sh1;
    logic [63:0] sh2;

    logic [1:0]  func_reg;
    logic [31:0] rmin_reg;
    logic [31:0] rmax_reg;
    logic [6:0]  chance_reg;

    logic [63:0] p_ll_reg;
    logic [31:0] p_hl_reg;
    logic [31:0] p_lh_reg;
    logic [63:0] raw_reg;
    logic [63:0] raw_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    logic [31:0] span32;
    logic [63:0] span64;
    logic        span_zero;
    logic        is_rng;
    logic        is_pct;
    logic [63:0] divisor;
    logic        div_done;
    logic [63:0] div_rem;

    logic [63:0] out_raw_reg;
    logic [31:0] out_range_reg;
    logic [31:0] out_range_next;
    logic        out_hit_reg;
    logic        out_hit_next;
    logic        out_err_reg;
    logic        out_err_next;
    logic [63:0] out_state_reg;

    // xorshift step
    assign sh1            = rng_state_reg ^ (rng_state_reg >> xs64r_pkg::SHIFT_A);
    assign sh2            = sh1 ^ (sh1 << xs64r_pkg::SHIFT_B);
    assign rng_state_next = sh2 ^ (sh2 >> xs64r_pkg::SHIFT_C);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rng_state_reg <= xs64r_pkg::SEED_RESET;
        end else if (cmd.seed_load) begin
            rng_state_reg <= cfg_data;
        end else if (cmd.adv) begin
            rng_state_reg <= rng_state_next;
        end
    end

    // shared 32x32 multiplier, low 64 bits of state times constant
    always_comb begin
        unique case (cmd.mul_op)
            xs64r_pkg::MUL_HL: begin
                mul_a = rng_state_reg[63:32];
                mul_b = xs64r_pkg::MULT_CONST[31:0];
            end
            xs64r_pkg::MUL_LH: begin
                mul_a = rng_state_reg[31:0];
                mul_b = xs64r_pkg::MULT_CONST[63:32];
            end
            default: begin
                mul_a = rng_state_reg[31:0];
                mul_b = xs64r_pkg::MULT_CONST[31:0];
            end
        endcase
    end

    assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
    assign raw_next = p_ll_reg + {p_hl_reg + p_lh_reg, 32'd0};

    assign is_rng    = (func_reg == xs64r_pkg::FUNC_RANGE);
    assign is_pct    = (func_reg == xs64r_pkg::FUNC_PCT);
    assign span32    = rmax_reg - rmin_reg + 32'd1;
    assign span64    = {{32{span32[31]}}, span32};
    assign span_zero = (span32 == 32'd0);
    assign divisor   = is_pct ? xs64r_pkg::PCT_DIV : span64;

    assign stat.need_div = (is_rng && !span_zero) || is_pct;
    assign stat.div_done = div_done;

    xs64r_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (raw_reg),
        .divisor  (divisor),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_comb begin
        out_range_next = 32'd0;
        out_hit_next   = 1'b0;
        out_err_next   = 1'b0;
        if (is_rng) begin
            out_err_next   = span_zero;
            out_range_next = span_zero ? rmin_reg : div_rem[31:0] + rmin_reg;
        end else if (is_pct) begin
            out_hit_next = (div_rem < {57'd0, chance_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            func_reg   <= s_tuser;
            rmin_reg   <= s_tdata[31:0];
            rmax_reg   <= s_tdata[63:32];
            chance_reg <= s_tdata[70:64];
        end
        case (cmd.mul_op)
            xs64r_pkg::MUL_LL: p_ll_reg <= mul_p;
            xs64r_pkg::MUL_HL: p_hl_reg <= mul_p[31:0];
            xs64r_pkg::MUL_LH: p_lh_reg <= mul_p[31:0];
            default: ;
        endcase
        if (cmd.raw_load) begin
            raw_reg <= raw_next;
        end
        if (cmd.out_load) begin
            out_raw_reg   <= raw_reg;
            out_range_reg <= out_range_next;
            out_hit_reg   <= out_hit_next;
            out_err_reg   <= out_err_next;
            out_state_reg <= rng_state_reg;
        end
    end

    assign m_tdata = {6'd0, out_state_reg, out_err_reg, out_hit_reg, out_range_reg, out_raw_reg};

endmodule

@@ rtl/xs64r_chk.sv @@
module xs64r_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [xs64r_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);

    // output empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

    // one request in flight
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // seed writes only while idle
    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |-> s_tready)
        else $error("seed write during a request");

    // error and hit never together
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[97] |-> !m_tdata[96])
        else $error("range error with chance hit");

endmodule

bind xorshift64star_range_rng_top xs64r_chk u_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

@@ verif/tb_xorshift64star_range_rng_top.sv @@
`timescale 1ns / 100ps

typedef struct packed {
    logic [63:0] raw;
    logic [31:0] range_val;
    logic        hit;
    logic        err;
    logic [63:0] state_after;
} draw_t;

class draw_tracker;
    logic [63:0] gen_state;
    draw_t       pending_draws[$];
    int          bad_words;

    function new();
        gen_state = xs64r_pkg::SEED_RESET;
        bad_words = 0;
    endfunction

    function void load_seed(logic [63:0] seed);
        gen_state = seed;
    endfunction

    function int pending();
        return pending_draws.size();
    endfunction

    function void note_request(logic [1:0] kind, logic [31:0] rmin, logic [31:0] rmax,
                               logic [6:0] chance);
        logic [63:0] s;
        logic [31:0] span32;
        logic [63:0] span;
        logic [63:0] rem;
        draw_t       d;
        s = gen_state;
        s = s ^ (s >> xs64r_pkg::SHIFT_A);
        s = s ^ (s << xs64r_pkg::SHIFT_B);
        s = s ^ (s >> xs64r_pkg::SHIFT_C);
        gen_state = s;
        d = '0;
        d.raw = s * xs64r_pkg::MULT_CONST;
        d.state_after = s;
        if (kind == xs64r_pkg::FUNC_RANGE) begin
            span32 = rmax - rmin + 32'd1;
            // span is sign-extended, then used as an unsigned divisor
            span = {{32{span32[31]}}, span32};
            if (span == 64'd0) begin
                d.err = 1'b1;
                d.range_val = rmin;
            end else begin
                rem = d.raw % span;
                d.range_val = rem[31:0] + rmin;
            end
        end else if (kind == xs64r_pkg::FUNC_PCT) begin
            d.hit = (d.raw % xs64r_pkg::PCT_DIV) < {57'd0, chance};
        end
        pending_draws.push_back(d);
    endfunction

    function void check_word(logic [xs64r_pkg::M_TDATA_W-1:0] word);
        draw_t got;
        draw_t exp;
        got.raw         = word[63:0];
        got.range_val   = word[95:64];
        got.hit         = word[96];
        got.err         = word[97];
        got.state_after = word[161:98];
        if (pending_draws.size() == 0) begin
            bad_words++;
            if (bad_words <= 10)
                $display("unexpected word raw=%h range=%h hit=%b err=%b state=%h",
                         got.raw, got.range_val, got.hit, got.err, got.state_after);
            return;
        end
        exp = pending_draws.pop_front();
        if (got.raw !== exp.raw || got.range_val !== exp.range_val ||
            got.hit !== exp.hit || got.err !== exp.err ||
            got.state_after !== exp.state_after) begin
            bad_words++;
            if (bad_words <= 10) begin
                $display("word mismatch exp raw=%h range=%h hit=%b err=%b state=%h",
                         exp.raw, exp.range_val, exp.hit, exp.err, exp.state_after);
                $display("              got raw=%h range=%h hit=%b err=%b state=%h",
                         got.raw, got.range_val, got.hit, got.err, got.state_after);
            end
        end
    endfunction
endclass

module tb_xorshift64star_range_rng_top;

    localparam logic [1:0] FUNC_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT  = 600000;
    localparam int         RANDOM_ITEMS = 1700;
    localparam int         PHASES       = 7;
    localparam int         DRAIN_CYCLES = 60;
    localparam int         IDLE_PCT     = 31;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [xs64r_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic [xs64r_pkg::S_TUSER_W-1:0] s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [xs64r_pkg::M_TDATA_W-1:0] m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [63:0]                     cfg_data  = '0;
    logic                            pace_gaps = 1'b1;
    int                              cycle_count = 0;
    draw_tracker                     tracker = new();

    xorshift64star_range_rng_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= !pace_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_word(m_tdata);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_xorshift64star_range_rng_top: errors");
        $finish;
    end

    task automatic send_request(input logic [1:0] kind, input logic [31:0] rmin,
                                input logic [31:0] rmax, input logic [6:0] chance);
        @(negedge aclk);
        while (pace_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, chance, rmax, rmin};
        do @(posedge aclk); while (!s_tready);
        tracker.note_request(kind, rmin, rmax, chance);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [63:0] seed);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        do @(posedge aclk); while (!cfg_ready);
        tracker.load_seed(seed);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random();
        logic [1:0]  kind;
        logic [31:0] rmin;
        logic [31:0] rmax;
        logic [6:0]  chance;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 20)
            kind = xs64r_pkg::FUNC_RAW;
        else if (pick < 65)
            kind = xs64r_pkg::FUNC_RANGE;
        else if (pick < 95)
            kind = xs64r_pkg::FUNC_PCT;
        else
            kind = FUNC_SPARE;
        rmin = $urandom;
        rmax = $urandom;
        case ($urandom_range(5))
            0, 1: rmax = rmin + 32'($urandom_range(1000));
            2: rmax = rmin - 32'd1;
            3: ;
            4: begin
                rmin = 32'($urandom_range(200)) - 32'd100;
                rmax = rmin + 32'($urandom_range(20));
            end
            default: rmax = rmin;
        endcase
        if ($urandom_range(3) == 0)
            chance = 7'($urandom_range(127));
        else
            chance = 7'($urandom_range(100));
        send_request(kind, rmin, rmax, chance);
    endtask

    initial begin
        logic [63:0] seed;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset seed
        send_request(xs64r_pkg::FUNC_RAW, 32'd0, 32'd0, 7'd0);
        send_request(FUNC_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F);
        send_request(xs64r_pkg::FUNC_RANGE, 32'd0, 32'd9, 7'd0);
        send_request(xs64r_pkg::FUNC_RANGE, 32'h8000_0000, 32'h7FFF_FFFF, 7'd0);
        send_request(xs64r_pkg::FUNC_RANGE, 32'd0, 32'hFFFF_FFFF, 7'd0);
        send_request(xs64r_pkg::FUNC_RANGE, 32'd5, -32'sd5, 7'd0);
        send_request(xs64r_pkg::FUNC_RANGE, 32'h8000_0000, 32'hFFFF_FFFF, 7'd0);
        send_request(xs64r_pkg::FUNC_RANGE, 32'd7, 32'd7, 7'd0);
        send_request(xs64r_pkg::FUNC_RANGE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd0);
        send_request(xs64r_pkg::FUNC_RANGE, -32'sd100, 32'd100, 7'd0);
        send_request(xs64r_pkg::FUNC_PCT, 32'd0, 32'd0, 7'd0);
        send_request(xs64r_pkg::FUNC_PCT, 32'd0, 32'd0, 7'd50);
        send_request(xs64r_pkg::FUNC_PCT, 32'd0, 32'd0, 7'd100);
        send_request(xs64r_pkg::FUNC_PCT, 32'd0, 32'd0, 7'd101);
        send_request(xs64r_pkg::FUNC_PCT, 32'd0, 32'd0, 7'h7F);
        drain_results();

        write_seed('1);
        send_request(xs64r_pkg::FUNC_RAW, 32'd0, 32'd0, 7'd0);
        send_request(xs64r_pkg::FUNC_RANGE, 32'h8000_0000, 32'h7FFF_FFFE, 7'd0);
        send_request(xs64r_pkg::FUNC_PCT, 32'd0, 32'd0, 7'd99);
        drain_results();

        // zero seed stays stuck at zero
        write_seed('0);
        send_request(xs64r_pkg::FUNC_RAW, 32'd0, 32'd0, 7'd0);
        send_request(xs64r_pkg::FUNC_RANGE, -32'sd3, 32'd3, 7'd0);
        send_request(xs64r_pkg::FUNC_PCT, 32'd0, 32'd0, 7'd1);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                1: seed = '1;
                2: seed = 64'h8000_0000_0000_0000;
                4: seed = xs64r_pkg::SEED_RESET;
                default: seed = {$urandom, $urandom};
            endcase
            // one phase runs both sides flat out
            pace_gaps = (ph != 3);
            write_seed(seed);
            repeat (RANDOM_ITEMS / PHASES) send_random();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.bad_words == 0 && tracker.pending() == 0)
            $display("tb_xorshift64star_range_rng_top: clean");
        else
            $display("tb_xorshift64star_range_rng_top: errors");
        $finish;
    end

endmodule
